### design/polynomial_term_store_evaluator_unit_defines.svh
// Assertion helpers used by the top-level design file.
`ifndef POLYNOMIAL_TERM_STORE_EVALUATOR_UNIT_DEFINES_SVH
`define POLYNOMIAL_TERM_STORE_EVALUATOR_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PSTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define PSTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pste_pkg.sv
package pste_pkg;

  localparam int unsigned DataW          = 32;
  localparam int unsigned ExpW           = 4;
  localparam int unsigned DefMaxTerms    = 16;
  localparam int unsigned DefFracBits    = 16;

  typedef enum logic {
    OpAdd  = 1'b0,
    OpEval = 1'b1
  } opcode_e;

  typedef enum logic {
    StIdle,
    StEval
  } state_e;

  // Controls for the coefficient ring.
  typedef struct packed {
    logic add;    // apply the add request to the addressed cell
    logic shift;  // rotate the ring by one cell
  } cell_ctrl_t;

  // Controls for the Horner unit.
  typedef struct packed {
    logic clear;  // zero the accumulator, latch x
    logic step;   // run one multiply-add
  } mac_ctrl_t;

  typedef struct packed {
    logic [DataW-1:0] val;
    logic             sat;
  } sat_res_t;

  // Signed add, clamped to the 32-bit range.
  function automatic sat_res_t sat_add(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    logic [DataW:0] sum;
    sat_res_t       res;
    sum = {a[DataW-1], a} + {b[DataW-1], b};
    res.sat = sum[DataW] ^ sum[DataW-1];
    if (!res.sat) begin
      res.val = sum[DataW-1:0];
    end else if (sum[DataW]) begin
      res.val = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      res.val = {1'b0, {(DataW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### design/pste_cell.sv
module pste_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pste_pkg::cell_ctrl_t          ctrl_i,
  input  logic                          hit_i,
  input  logic [pste_pkg::DataW-1:0]    coefficient_i,
  input  logic [pste_pkg::DataW-1:0]    prev_i,
  output logic [pste_pkg::DataW-1:0]    coef_o,
  output logic                          sat_o
);

  logic [pste_pkg::DataW-1:0] coef_q, coef_d;
  pste_pkg::sat_res_t         sum;

  assign sum   = pste_pkg::sat_add(coef_q, coefficient_i);
  assign sat_o = ctrl_i.add && hit_i && sum.sat;

  always_comb begin
    coef_d = coef_q;
    priority if (ctrl_i.shift) begin
      coef_d = prev_i;
    end else if (ctrl_i.add && hit_i) begin
      coef_d = sum.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

### design/pste_horner.sv
module pste_horner #(
  parameter int unsigned FRAC_BITS = pste_pkg::DefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pste_pkg::mac_ctrl_t           ctrl_i,
  input  logic [pste_pkg::DataW-1:0]    x_value_i,
  input  logic [pste_pkg::DataW-1:0]    coef_i,
  output logic [pste_pkg::DataW-1:0]    acc_o,
  output logic                          sat_o
);

  localparam int unsigned DW = pste_pkg::DataW;

  logic [DW-1:0]          acc_q, acc_d;
  logic [DW-1:0]          x_q, x_d;
  logic                   sat_q, sat_d;
  logic signed [2*DW-1:0] prod;
  logic signed [2*DW-1:0] prod_sh;
  logic [DW-1:0]          prod_c;
  logic                   prod_sat;
  pste_pkg::sat_res_t     sum;

  // Arithmetic shift floors toward minus infinity.
  assign prod    = $signed(acc_q) * $signed(x_q);
  assign prod_sh = prod >>> FRAC_BITS;

  always_comb begin
    prod_sat = !((&prod_sh[2*DW-1:DW-1]) || !(|prod_sh[2*DW-1:DW-1]));
    if (!prod_sat) begin
      prod_c = prod_sh[DW-1:0];
    end else if (prod_sh[2*DW-1]) begin
      prod_c = {1'b1, {(DW-1){1'b0}}};
    end else begin
      prod_c = {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign sum = pste_pkg::sat_add(prod_c, coef_i);

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    sat_d = sat_q;
    priority if (ctrl_i.clear) begin
      acc_d = '0;
      x_d   = x_value_i;
      sat_d = 1'b0;
    end else if (ctrl_i.step) begin
      acc_d = sum.val;
      sat_d = sat_q || prod_sat || sum.sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else begin
      sat_q <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;

endmodule

### design/polynomial_term_store_evaluator_unit.sv
// Polynomial term store and evaluator. Send a request with start_i while
// busy_o is low. An add request (opcode 0) adds the signed Q16.16
// coefficient into the entry for its exponent with saturation, gives no
// result and never raises busy_o; exponents at or above MAX_TERMS are
// dropped. An evaluate request (opcode 1) holds busy_o high while the
// coefficient ring rotates past one Horner multiply-add unit, highest
// exponent first, one coefficient per cycle; the result then shows on
// poly_value_o and overflow_o for exactly one cycle with valid_o high. The
// next request is taken in that result cycle. The receiver cannot stall:
// capture the result when valid_o is high or it is gone. overflow_o reports
// any saturation in this evaluation or any saturated add since reset.
// Reset clears all coefficients.

`include "polynomial_term_store_evaluator_unit_defines.svh"

module polynomial_term_store_evaluator_unit #(
  parameter int unsigned MAX_TERMS = pste_pkg::DefMaxTerms,
  parameter int unsigned FRAC_BITS = pste_pkg::DefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          opcode_i,
  input  logic [pste_pkg::ExpW-1:0]     exponent_i,
  input  logic [pste_pkg::DataW-1:0]    coefficient_i,
  input  logic [pste_pkg::DataW-1:0]    x_value_i,
  output logic                          valid_o,
  output logic [pste_pkg::DataW-1:0]    poly_value_o,
  output logic                          overflow_o
);

  localparam int unsigned DW    = pste_pkg::DataW;
  localparam int unsigned EW    = pste_pkg::ExpW;
  localparam int unsigned IDX_W = $clog2(MAX_TERMS);
  localparam int unsigned CMP_W = (IDX_W > EW) ? IDX_W : EW;
  localparam logic [IDX_W-1:0] LastStep = IDX_W'(MAX_TERMS - 1);

  pste_pkg::state_e     state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic                 valid_q, valid_d;
  logic                 sticky_q, sticky_d;

  pste_pkg::cell_ctrl_t cell_ctrl;
  pste_pkg::mac_ctrl_t  mac_ctrl;

  logic                 req_go;
  logic                 add_go;
  logic                 eval_go;
  logic [CMP_W-1:0]     exp_cmp;

  logic [DW-1:0]        ring [MAX_TERMS];
  logic [MAX_TERMS-1:0] hit;
  logic [MAX_TERMS-1:0] cell_sat;
  logic [DW-1:0]        acc;
  logic                 eval_sat;

  // Request decode: a request is taken only while idle.
  assign req_go  = start_i && !busy_o;
  assign add_go  = req_go && (opcode_i == pste_pkg::OpAdd);
  assign eval_go = req_go && (opcode_i == pste_pkg::OpEval);
  assign exp_cmp = CMP_W'(exponent_i);

  // Coefficient ring: cell g holds the coefficient of x^g while idle. While
  // evaluating, each cell takes its lower neighbor's value and the top cell
  // feeds the Horner unit; after MAX_TERMS shifts every entry is home again.
  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
    localparam int unsigned Prev = (g == 0) ? MAX_TERMS - 1 : g - 1;

    assign hit[g] = (exp_cmp == CMP_W'(g));

    pste_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .hit_i         (hit[g]),
      .coefficient_i (coefficient_i),
      .prev_i        (ring[Prev]),
      .coef_o        (ring[g]),
      .sat_o         (cell_sat[g])
    );
  end

  // One multiply-add per cycle while evaluating: acc = sat(sat(acc * x) + coefficient).
  pste_horner #(
    .FRAC_BITS (FRAC_BITS)
  ) u_horner (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .x_value_i (x_value_i),
    .coef_i    (ring[MAX_TERMS-1]),
    .acc_o     (acc),
    .sat_o     (eval_sat)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pste_pkg::StIdle: begin
        if (eval_go) begin
          state_d = pste_pkg::StEval;
        end
      end
      pste_pkg::StEval: begin
        if (cnt_q == LastStep) begin
          state_d = pste_pkg::StIdle;
        end
      end
      default: state_d = pste_pkg::StIdle;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    cell_ctrl = '0;
    mac_ctrl  = '0;
    cnt_d     = '0;
    valid_d   = 1'b0;
    unique case (state_q)
      pste_pkg::StIdle: begin
        cell_ctrl.add  = add_go;
        mac_ctrl.clear = eval_go;
      end
      pste_pkg::StEval: begin
        cell_ctrl.shift = 1'b1;
        mac_ctrl.step   = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        // Flag the result for the cycle after the last step.
        valid_d         = (cnt_q == LastStep);
        if (cnt_q == LastStep) begin
          cnt_d = '0;
        end
      end
      default: ;
    endcase
  end

  // Hold any saturated add until reset.
  assign sticky_d = sticky_q || (|cell_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pste_pkg::StIdle;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
      sticky_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
      sticky_q <= sticky_d;
    end
  end

  assign busy_o       = (state_q == pste_pkg::StEval);
  assign valid_o      = valid_q;
  assign poly_value_o = acc;
  assign overflow_o   = eval_sat || sticky_q;

  `PSTE_ASSERT_NEXT(a_eval_starts, eval_go, busy_o && (cnt_q == '0), "evaluate did not start")
  `PSTE_ASSERT_NOW(a_idle_cnt, !busy_o, cnt_q == '0, "step counter moved while idle")
  `PSTE_ASSERT_NOW(a_res_after_eval, valid_o, !busy_o && $past(busy_o), "result without evaluation")
  `PSTE_ASSERT_NOW(a_no_add_busy, busy_o, !cell_ctrl.add, "add applied during evaluation")

endmodule

### tb/tb_polynomial_term_store_evaluator_unit.sv
module tb_polynomial_term_store_evaluator_unit;

  timeunit 1ns;
  timeprecision 1ps;

  // Table geometry and fixed-point format of the default build.
  localparam int NumTerms = pste_pkg::DefMaxTerms;
  localparam int FracBits = pste_pkg::DefFracBits;
  localparam int DataW    = pste_pkg::DataW;
  localparam int ExpW     = pste_pkg::ExpW;

  // Signed 32-bit saturation bounds, held at 64 bits for the sum and product checks.
  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  // Q16.16 constants used by the directed requests.
  localparam logic [DataW-1:0] QOne     = 32'h0001_0000;
  localparam logic [DataW-1:0] QTwo     = 32'h0002_0000;
  localparam logic [DataW-1:0] QHalf    = 32'h0000_8000;
  localparam logic [DataW-1:0] QMinusOne = 32'hFFFF_0000;
  localparam logic [DataW-1:0] QPosMax  = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] QNegMax  = 32'h8000_0000;

  localparam int RandomRequests = 1200;

  typedef struct {
    logic [DataW-1:0] value;
    logic             ovf;
  } poly_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 opcode_i;
  logic [ExpW-1:0]      exponent_i;
  logic [DataW-1:0]     coefficient_i;
  logic [DataW-1:0]     x_value_i;
  logic                 valid_o;
  logic [DataW-1:0]     poly_value_o;
  logic                 overflow_o;

  // Shadow copy of the coefficient table and the sticky add-saturation flag.
  int                   coef_table [NumTerms];
  bit                   add_sat_sticky;

  // Evaluation results still owed by the block, oldest first.
  poly_result_t         pending_evals [$];

  int                   error_count;
  int                   adds_sent;
  int                   evals_sent;
  int                   evals_checked;
  int                   evals_with_ovf;
  int                   evals_clamped;
  bit                   gaps_on;

  polynomial_term_store_evaluator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .exponent_i    (exponent_i),
    .coefficient_i (coefficient_i),
    .x_value_i     (x_value_i),
    .valid_o       (valid_o),
    .poly_value_o  (poly_value_o),
    .overflow_o    (overflow_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Saturating fixed-point helpers for the shadow evaluator.
  // ---------------------------------------------------------------------------

  function automatic bit fits_q32(input longint v);
    return (v <= QMax) && (v >= QMin);
  endfunction

  function automatic int clamp_q32(input longint v);
    if (v > QMax) begin
      return int'(QMax);
    end else if (v < QMin) begin
      return int'(QMin);
    end
    return int'(v);
  endfunction

  // Horner's rule over the whole table, highest exponent first. The product
  // shift is arithmetic, so it rounds toward minus infinity before clamping.
  function automatic void horner_eval(input int x, output int value, output bit ovf);
    int     acc;
    longint prod;
    longint sum;
    bit     sat;
    acc = 0;
    sat = 1'b0;
    for (int k = NumTerms - 1; k >= 0; k--) begin
      prod = (longint'(acc) * longint'(x)) >>> FracBits;
      if (!fits_q32(prod)) sat = 1'b1;
      acc = clamp_q32(prod);
      sum = longint'(acc) + longint'(coef_table[k]);
      if (!fits_q32(sum)) sat = 1'b1;
      acc = clamp_q32(sum);
    end
    value = acc;
    ovf   = sat | add_sat_sticky;
  endfunction

  // Most gaps are short, a few are long enough to cover a whole evaluation.
  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 9) return 0;
    if (roll < 17) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Send one request: idle for a random gap, present the fields, hold start_i
  // until the block takes it, then update the shadow state. Returns just after
  // the next falling edge with start_i still high, so a back-to-back request
  // never drops it.
  // ---------------------------------------------------------------------------
  task automatic send_request(input pste_pkg::opcode_e op, input logic [ExpW-1:0] exp,
                              input logic [DataW-1:0] coef, input logic [DataW-1:0] x);
    int           gap;
    longint       sum;
    int           value;
    bit           ovf;
    poly_result_t want;
    gap = pick_gap();
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i      = op;
    exponent_i    = exp;
    coefficient_i = coef;
    x_value_i     = x;
    start_i       = 1'b1;
    // Hold the request until an edge finds the block idle.
    do @(posedge clk_i); while (busy_o);
    if (op == pste_pkg::OpAdd) begin
      sum = longint'(coef_table[exp]) + longint'(int'(coef));
      if (!fits_q32(sum)) add_sat_sticky = 1'b1;
      coef_table[exp] = clamp_q32(sum);
      adds_sent++;
    end else begin
      horner_eval(int'(x), value, ovf);
      want.value = value;
      want.ovf   = ovf;
      pending_evals.push_back(want);
      evals_sent++;
      if (ovf) evals_with_ovf++;
      if (longint'(value) == QMax || longint'(value) == QMin) evals_clamped++;
    end
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each strobed result must match the oldest pending one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    poly_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_evals.size() == 0) begin
        $error("result with nothing pending: poly_value=%h overflow=%b",
               poly_value_o, overflow_o);
        error_count++;
      end else begin
        want = pending_evals.pop_front();
        evals_checked++;
        if (poly_value_o !== want.value) begin
          $error("poly_value mismatch: expected %h, actual %h", want.value, poly_value_o);
          error_count++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow mismatch: expected %b, actual %b", want.ovf, overflow_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // A freshly cleared table evaluates to zero with no overflow anywhere.
  task automatic test_empty_polynomial();
    send_request(pste_pkg::OpEval, 4'hF, QPosMax, 32'h0000_0000);
    send_request(pste_pkg::OpEval, 4'h0, QNegMax, QPosMax);
    send_request(pste_pkg::OpEval, 4'h5, 32'h1234_5678, QNegMax);
  endtask

  // Build up terms one at a time; push the top term to the negative bound so
  // that products clamp in both directions without touching the sticky flag.
  task automatic test_single_terms();
    send_request(pste_pkg::OpAdd,  4'h0, QOne, $urandom);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QTwo);
    send_request(pste_pkg::OpAdd,  4'h1, QOne, $urandom);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QTwo);
    send_request(pste_pkg::OpAdd,  4'hF, QNegMax, $urandom);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QOne);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QTwo);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QMinusOne);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QNegMax);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QPosMax);
  endtask

  // Leave a top term of -1 LSB: times one half it must floor to -1, not 0.
  task automatic test_product_rounding();
    send_request(pste_pkg::OpAdd,  4'hF, QPosMax, $urandom);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QHalf);
    send_request(pste_pkg::OpAdd,  4'hF, 32'h0000_0001, $urandom);
    send_request(pste_pkg::OpAdd,  4'h7, QPosMax, $urandom);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QOne);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QPosMax);
  endtask

  // ---------------------------------------------------------------------------
  // Random sequences: a burst of zero to six adds followed by one or two evaluations.
  // Adds that would saturate are steered to a value that cannot, so the sticky
  // flag stays clear and overflow keeps reflecting each evaluation on its own.
  // ---------------------------------------------------------------------------
  task automatic test_random_sequences();
    int              sent;
    int              n_adds;
    int              n_evals;
    logic [ExpW-1:0] exp;
    int              coef;
    int              x;
    sent = 0;
    while (sent < RandomRequests) begin
      // Run about a quarter of the rounds back to back.
      gaps_on = ($urandom_range(0, 3) != 0);
      n_adds  = $urandom_range(0, 6);
      repeat (n_adds) begin
        exp = ExpW'($urandom_range(0, NumTerms - 1));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: coef = int'($urandom_range(0, 1 << 15)) - (1 << 14);
          4, 5:       coef = int'($urandom_range(0, 1 << 25)) - (1 << 24);
          6, 7:       coef = $urandom;
          default:    coef = -coef_table[exp];
        endcase
        if (!fits_q32(longint'(coef_table[exp]) + longint'(coef))) coef = ~coef_table[exp];
        send_request(pste_pkg::OpAdd, exp, coef, $urandom);
        sent++;
      end
      n_evals = $urandom_range(1, 2);
      repeat (n_evals) begin
        case ($urandom_range(0, 7))
          0, 1, 2, 3: x = int'($urandom_range(0, 1 << 18)) - (1 << 17);
          4: begin
            case ($urandom_range(0, 2))
              0:       x = 0;
              1:       x = int'(QOne);
              default: x = int'(QMinusOne);
            endcase
          end
          5:          x = int'($urandom_range(0, 1 << 16)) - (1 << 15);
          default:    x = $urandom;
        endcase
        send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, x);
        sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // Saturating adds set the sticky flag for good, so run this last.
  task automatic test_sticky_overflow();
    send_request(pste_pkg::OpAdd,  4'h3, QPosMax, $urandom);
    send_request(pste_pkg::OpAdd,  4'h3, QPosMax, $urandom);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, 32'h0000_0000);
    send_request(pste_pkg::OpAdd,  4'h4, QNegMax, $urandom);
    send_request(pste_pkg::OpAdd,  4'h4, QNegMax, $urandom);
    send_request(pste_pkg::OpEval, ExpW'($urandom), $urandom, QHalf);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    opcode_i       = pste_pkg::OpAdd;
    exponent_i     = '0;
    coefficient_i  = '0;
    x_value_i      = '0;
    error_count    = 0;
    adds_sent      = 0;
    evals_sent     = 0;
    evals_checked  = 0;
    evals_with_ovf = 0;
    evals_clamped  = 0;
    gaps_on        = 1'b1;
    add_sat_sticky = 1'b0;
    foreach (coef_table[k]) coef_table[k] = 0;

    // Hold reset, then release it away from the sampling edge.
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_polynomial();
    test_single_terms();
    test_product_rounding();
    test_random_sequences();
    test_sticky_overflow();
    start_i = 1'b0;

    // Drain every owed result, then keep the clock running so that any stray
    // strobe still shows.
    while (pending_evals.size() != 0) @(posedge clk_i);
    repeat (2 * NumTerms + 8) @(posedge clk_i);

    $display("Covered %0d add and %0d evaluate requests, %0d results checked.",
             adds_sent, evals_sent, evals_checked);
    $display("Evaluations flagging overflow: %0d, clamped to a bound: %0d.",
             evals_with_ovf, evals_clamped);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Bound the run well above the slowest legal schedule.
  initial begin
    #10ms;
    $display("Timed out with %0d results pending.", pending_evals.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
